### src/pidd_pkg.sv
// ----------------------------------------------------------------------------
// pidd_pkg: shared types and constants of the integer PID deadband unit
// Field widths, arithmetic widths of the shared units, register indexes and
// the configuration bundle handed from the register file to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pidd_pkg;

    // Field widths
    localparam int DATA_W = 24;
    localparam int GAIN_W = 16;
    localparam int TIME_W = 32;
    localparam int BAND_W = DATA_W - 1;
    localparam int ERR_W  = DATA_W + 1;

    // Magnitude of a gain times an error or a measurement step
    localparam int MAG_W  = GAIN_W + DATA_W;
    // Shared multiplier operand and product widths
    localparam int MOP_W  = TIME_W;
    localparam int PROD_W = 2 * MOP_W;
    // The wide integral product is split into two halves of the magnitude
    localparam int HALF_W = (MAG_W + 1) / 2;
    localparam int ACC_W  = MAG_W + TIME_W + 1;

    // Wide intermediates saturate at +/- 2^SAT_SHIFT
    localparam int SAT_SHIFT = 61;
    localparam int SUM_W     = SAT_SHIFT + 3;

    // Divider step counter
    localparam int CNT_W = $clog2(MAG_W);

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING  = 3'd4;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic signed [DATA_W-1:0] floor_lim;
        logic signed [DATA_W-1:0] ceil_lim;
    } t_cfg;

endpackage

### src/pid_integer_deadband_unit.sv
// ----------------------------------------------------------------------------
// pid_integer_deadband_unit: integer PID step with deadband
// Derivative on measurement, integral and output clamped to programmable
// limits, one shared multiplier and a serial divider under a sequencer.
// ----------------------------------------------------------------------------
// Usage:
// A request on the input channel (i_in_valid, o_in_stall) carries target,
// measured, deadband and a microsecond timestamp. Each request yields one
// drive value on the output channel (o_out_valid, i_out_stall).
// Inside the deadband the sequencer goes from its check state straight to
// its final state. Otherwise it feeds the shared multiplier in states S_MP,
// S_MI, S_MD, S_MLO and S_MHI, and the derivative divide runs in the serial
// divider; when the elapsed time is zero no divide is needed.
// The block holds o_in_stall high from the request until its result is
// loaded into the output register, so one request is in flight at a time.
// The output register frees the input side: a new request is taken while a
// result still waits. If the receiver stalls and a new result is ready, the
// sequencer waits in its last state until the output register is free.
// Reset clears the gains, sets the limits to the full data range and clears
// the stored time, measurement and integral. Configuration writes are taken
// every cycle and belong in idle periods.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_integer_deadband_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [pidd_pkg::DATA_W-1:0]    i_target,
    input  logic signed [pidd_pkg::DATA_W-1:0]    i_measured,
    input  logic [pidd_pkg::BAND_W-1:0]           i_deadband,
    input  logic [pidd_pkg::TIME_W-1:0]           i_timestamp_us,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [pidd_pkg::DATA_W-1:0]    o_drive,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pidd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pidd_pkg::DATA_W-1:0]           i_cfg_data
);
    import pidd_pkg::*;

    localparam int P_W    = MAG_W + 1;
    localparam int DSUM_W = MAG_W + 2;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_MP    = 4'd2;
    localparam logic [3:0] S_MI    = 4'd3;
    localparam logic [3:0] S_MD    = 4'd4;
    localparam logic [3:0] S_MLO   = 4'd5;
    localparam logic [3:0] S_MHI   = 4'd6;
    localparam logic [3:0] S_MACC  = 4'd7;
    localparam logic [3:0] S_ISUM  = 4'd8;
    localparam logic [3:0] S_ILIM  = 4'd9;
    localparam logic [3:0] S_DIV   = 4'd10;
    localparam logic [3:0] S_DSUM  = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    localparam logic [ACC_W-1:0] SAT_ACC =
        {{(ACC_W-SAT_SHIFT-1){1'b0}}, 1'b1, {SAT_SHIFT{1'b0}}};

    // Above the ceiling wins over below the floor when the limits cross.
    function automatic logic signed [DATA_W-1:0] f_limit(
        input logic signed [SUM_W-1:0]  v,
        input logic signed [DATA_W-1:0] lo,
        input logic signed [DATA_W-1:0] hi
    );
        logic signed [SUM_W-1:0] lo_x;
        logic signed [SUM_W-1:0] hi_x;
        lo_x = {{(SUM_W-DATA_W){lo[DATA_W-1]}}, lo};
        hi_x = {{(SUM_W-DATA_W){hi[DATA_W-1]}}, hi};
        if (v > hi_x) begin
            return hi;
        end else if (v < lo_x) begin
            return lo;
        end
        return v[DATA_W-1:0];
    endfunction

    t_cfg cfg;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_load;
    logic       in_take;

    // Stored controller state
    logic [TIME_W-1:0]        r_prev_time;
    logic signed [DATA_W-1:0] r_prev_meas;
    logic signed [DATA_W-1:0] r_integral;

    // Per-request working registers
    logic signed [ERR_W-1:0]  r_err;
    logic signed [ERR_W-1:0]  r_dmeas;
    logic signed [DATA_W-1:0] r_meas;
    logic [BAND_W-1:0]        r_band;
    logic [TIME_W-1:0]        r_time;
    logic [TIME_W-1:0]        r_dt;
    logic                     r_dead;
    logic signed [P_W-1:0]    r_prop;
    logic [MAG_W-1:0]         r_amag;
    logic                     r_aneg;
    logic [MAG_W-1:0]         r_dmag;
    logic                     r_dneg;
    logic [ACC_W-1:0]         r_acc;
    logic signed [SUM_W-1:0]  r_isum;
    logic signed [DATA_W-1:0] r_integ;
    logic signed [DSUM_W-1:0] r_dsum;
    logic signed [DATA_W-1:0] r_drive;

    logic [ERR_W-1:0]   err_mag;
    logic [ERR_W-1:0]   dmeas_mag;
    logic [GAIN_W-1:0]  gp_mag;
    logic [GAIN_W-1:0]  gi_mag;
    logic [GAIN_W-1:0]  gd_mag;
    logic [MOP_W-1:0]   mul_a;
    logic [MOP_W-1:0]   mul_b;
    logic [PROD_W-1:0]  prod;
    logic               div_start;
    logic               div_busy;
    logic [MAG_W-1:0]   quot;
    logic               dead_hit;

    logic [SUM_W-1:0]         i_mag;
    logic signed [SUM_W-1:0]  i_term;
    logic signed [SUM_W-1:0]  integral_x;
    logic signed [DSUM_W-1:0] prop_x;
    logic signed [DSUM_W-1:0] integ_x;
    logic signed [DSUM_W-1:0] deriv_x;
    logic [DSUM_W-1:0]        quot_x;
    logic signed [SUM_W-1:0]  dsum_x;

    pidd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    pidd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    pidd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_dmag),
        .i_divisor  (r_dt),
        .o_busy     (div_busy),
        .o_quot     (quot)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_take     = i_in_valid && (r_state == S_IDLE);

    // Magnitudes feeding the shared multiplier
    assign err_mag   = r_err[ERR_W-1] ? (~r_err + 1'b1) : r_err;
    assign dmeas_mag = r_dmeas[ERR_W-1] ? (~r_dmeas + 1'b1) : r_dmeas;
    assign gp_mag    = cfg.gain_p[GAIN_W-1] ? (~cfg.gain_p + 1'b1) : cfg.gain_p;
    assign gi_mag    = cfg.gain_i[GAIN_W-1] ? (~cfg.gain_i + 1'b1) : cfg.gain_i;
    assign gd_mag    = cfg.gain_d[GAIN_W-1] ? (~cfg.gain_d + 1'b1) : cfg.gain_d;
    assign dead_hit  = (err_mag <= {2'b00, r_band});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MP: begin
                mul_a = MOP_W'(gp_mag);
                mul_b = MOP_W'(err_mag);
            end
            S_MI: begin
                mul_a = MOP_W'(gi_mag);
                mul_b = MOP_W'(err_mag);
            end
            S_MD: begin
                mul_a = MOP_W'(gd_mag);
                mul_b = MOP_W'(dmeas_mag);
            end
            S_MLO: begin
                mul_a = MOP_W'(r_amag[HALF_W-1:0]);
                mul_b = r_dt;
            end
            S_MHI: begin
                mul_a = MOP_W'(r_amag[MAG_W-1:HALF_W]);
                mul_b = r_dt;
            end
            default: begin
            end
        endcase
    end

    // A zero time step leaves the derivative at zero, so no divide is run.
    assign div_start = (r_state == S_MHI) && (r_dt != '0);

    // Integral term: saturate the wide product, restore its sign, add.
    assign i_mag      = (r_acc > SAT_ACC) ? SAT_ACC[SUM_W-1:0] : r_acc[SUM_W-1:0];
    assign i_term     = r_aneg ? -$signed(i_mag) : $signed(i_mag);
    assign integral_x = {{(SUM_W-DATA_W){r_integral[DATA_W-1]}}, r_integral};

    assign quot_x  = {2'b00, quot};
    assign deriv_x = (r_dt == '0) ? '0 : (r_dneg ? -$signed(quot_x) : $signed(quot_x));
    assign prop_x  = {{(DSUM_W-P_W){r_prop[P_W-1]}}, r_prop};
    assign integ_x = {{(DSUM_W-DATA_W){r_integ[DATA_W-1]}}, r_integ};
    assign dsum_x  = {{(SUM_W-DSUM_W){r_dsum[DSUM_W-1]}}, r_dsum};

    assign out_load = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CHECK;
            S_CHECK: n_state = dead_hit ? S_FIN : S_MP;
            S_MP:    n_state = S_MI;
            S_MI:    n_state = S_MD;
            S_MD:    n_state = S_MLO;
            S_MLO:   n_state = S_MHI;
            S_MHI:   n_state = S_MACC;
            S_MACC:  n_state = S_ISUM;
            S_ISUM:  n_state = S_ILIM;
            S_ILIM:  n_state = S_DIV;
            S_DIV:   if (!div_busy) n_state = S_DSUM;
            S_DSUM:  n_state = S_FIN;
            S_FIN:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_prev_time <= '0;
            r_prev_meas <= '0;
            r_integral  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (out_load && !r_dead) begin
                r_prev_time <= r_time;
                r_prev_meas <= r_meas;
                r_integral  <= r_integ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_err   <= {i_target[DATA_W-1], i_target} - {i_measured[DATA_W-1], i_measured};
            r_dmeas <= {i_measured[DATA_W-1], i_measured}
                     - {r_prev_meas[DATA_W-1], r_prev_meas};
            r_meas  <= i_measured;
            r_band  <= i_deadband;
            r_time  <= i_timestamp_us;
            r_dt    <= i_timestamp_us - r_prev_time;
        end
        if (r_state == S_CHECK) begin
            r_dead <= dead_hit;
        end
        if (r_state == S_MI) begin
            r_prop <= (cfg.gain_p[GAIN_W-1] ^ r_err[ERR_W-1])
                    ? -$signed({1'b0, prod[MAG_W-1:0]})
                    : $signed({1'b0, prod[MAG_W-1:0]});
        end
        if (r_state == S_MD) begin
            r_amag <= prod[MAG_W-1:0];
            r_aneg <= cfg.gain_i[GAIN_W-1] ^ r_err[ERR_W-1];
        end
        if (r_state == S_MLO) begin
            r_dmag <= prod[MAG_W-1:0];
            r_dneg <= cfg.gain_d[GAIN_W-1] ^ r_dmeas[ERR_W-1];
        end
        if (r_state == S_MHI) begin
            r_acc <= ACC_W'(prod);
        end
        if (r_state == S_MACC) begin
            r_acc <= r_acc + (ACC_W'(prod) << HALF_W);
        end
        if (r_state == S_ISUM) begin
            r_isum <= integral_x + i_term;
        end
        if (r_state == S_ILIM) begin
            r_integ <= f_limit(r_isum, cfg.floor_lim, cfg.ceil_lim);
        end
        if (r_state == S_DSUM) begin
            r_dsum <= prop_x + integ_x - deriv_x;
        end
        if (out_load) begin
            r_drive <= r_dead ? '0 : f_limit(dsum_x, cfg.floor_lim, cfg.ceil_lim);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;

endmodule

### src/pidd_cfg.sv
// ----------------------------------------------------------------------------
// pidd_cfg: configuration register file
// Holds the three gains and the output limits, written one at a time by
// index. Writes to an index beyond the register list are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pidd_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [pidd_pkg::CFG_IDX_W-1:0]   i_wr_index,
    input  logic [pidd_pkg::DATA_W-1:0]      i_wr_data,
    output pidd_pkg::t_cfg                   o_cfg
);
    import pidd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p    <= '0;
            r_cfg.gain_i    <= '0;
            r_cfg.gain_d    <= '0;
            r_cfg.floor_lim <= {1'b1, {(DATA_W-1){1'b0}}};
            r_cfg.ceil_lim  <= {1'b0, {(DATA_W-1){1'b1}}};
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                REG_GAIN_P:  r_cfg.gain_p    <= i_wr_data[GAIN_W-1:0];
                REG_GAIN_I:  r_cfg.gain_i    <= i_wr_data[GAIN_W-1:0];
                REG_GAIN_D:  r_cfg.gain_d    <= i_wr_data[GAIN_W-1:0];
                REG_FLOOR:   r_cfg.floor_lim <= i_wr_data;
                REG_CEILING: r_cfg.ceil_lim  <= i_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/pidd_mul.sv
// ----------------------------------------------------------------------------
// pidd_mul: shared unsigned multiplier
// One magnitude product per cycle with a registered result. The sequencer
// feeds it the gain products and both halves of the integral product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pidd_mul (
    input  logic                          i_clk,
    input  logic [pidd_pkg::MOP_W-1:0]    i_a,
    input  logic [pidd_pkg::MOP_W-1:0]    i_b,
    output logic [pidd_pkg::PROD_W-1:0]   o_prod
);
    import pidd_pkg::*;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

### src/pidd_div.sv
// ----------------------------------------------------------------------------
// pidd_div: restoring divider
// Divides an unsigned magnitude by the elapsed time, one quotient bit per
// cycle. The quotient truncates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pidd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pidd_pkg::MAG_W-1:0]    i_dividend,
    input  logic [pidd_pkg::TIME_W-1:0]   i_divisor,
    output logic                          o_busy,
    output logic [pidd_pkg::MAG_W-1:0]    o_quot
);
    import pidd_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAG_W - 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] r_den;
    logic [MAG_W-1:0]  r_quot;
    logic [TIME_W:0]   trial;
    logic [TIME_W:0]   diff;
    logic              fits;

    // The quotient register doubles as the dividend shift register.
    assign trial = {r_rem, r_quot[MAG_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_LAST;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_den  <= i_divisor;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            r_rem  <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
            r_quot <= {r_quot[MAG_W-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

### src/pidd_checker.sv
// ----------------------------------------------------------------------------
// pidd_checker: port-level checks of the PID deadband unit
// Watches the request and result channels of the top level over time and
// is attached to every instance of it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pidd_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [pidd_pkg::DATA_W-1:0]  o_drive
);
    import pidd_pkg::*;

    // A taken request keeps the block busy on the following cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input side free right after a request was taken");

    // A new result is loaded only while a request is being worked on.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared while the block was idle");

    // No result can be produced in the cycle right after a request is taken.
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid))
        else $error("result faster than the sequencer allows");

    // A stalled result stays valid and unchanged.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_drive)))
        else $error("stalled result dropped or changed");

endmodule

bind pid_integer_deadband_unit pidd_checker u_pidd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_drive     (o_drive)
);

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the integer PID deadband unit
// A scoreboard class tracks the gains, limits and loop state, predicts the
// drive of every accepted request and compares it with the block's output.
// Directed requests cover the deadband edge, zero and wrapping elapsed time,
// derivative rounding, saturation and crossed limits; random requests follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import pidd_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_BLOCKS  = 6;
    localparam int BLOCK_REQUESTS = 205;
    localparam int SETTLE_CYCLES  = 60;
    localparam int LIMIT_NS       = 4_000_000;

    localparam longint          WIDE_LIMIT   = 64'sd1 <<< SAT_SHIFT;
    localparam longint unsigned WIDE_LIMIT_U = 64'd1 << SAT_SHIFT;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
    localparam logic signed [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};
    localparam logic [BAND_W-1:0]        BAND_MAX = '1;

    class pid_scoreboard;
        t_cfg                     regs;
        logic [TIME_W-1:0]        last_stamp;
        logic signed [DATA_W-1:0] last_meas;
        logic signed [DATA_W-1:0] integ_acc;
        logic signed [DATA_W-1:0] drive_q[$];
        int errors;
        int requests;
        int in_band;
        int zero_dt;
        int checked;

        function new();
            regs.gain_p    = '0;
            regs.gain_i    = '0;
            regs.gain_d    = '0;
            regs.floor_lim = DATA_MIN;
            regs.ceil_lim  = DATA_MAX;
            last_stamp     = '0;
            last_meas      = '0;
            integ_acc      = '0;
            errors         = 0;
            requests       = 0;
            in_band        = 0;
            zero_dt        = 0;
            checked        = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                REG_GAIN_P:  regs.gain_p    = data[GAIN_W-1:0];
                REG_GAIN_I:  regs.gain_i    = data[GAIN_W-1:0];
                REG_GAIN_D:  regs.gain_d    = data[GAIN_W-1:0];
                REG_FLOOR:   regs.floor_lim = data;
                REG_CEILING: regs.ceil_lim  = data;
                default: ;
            endcase
        endfunction

        // Signed product that sticks at the wide saturation bound.
        function longint wide_product(longint a, longint b);
            longint unsigned ua;
            longint unsigned ub;
            longint unsigned p;
            bit              neg;
            neg = (a < 0) != (b < 0);
            ua  = (a < 0) ? -a : a;
            ub  = (b < 0) ? -b : b;
            if (ua != 0 && ub > WIDE_LIMIT_U / ua)
                return neg ? -WIDE_LIMIT : WIDE_LIMIT;
            p = ua * ub;
            return neg ? -longint'(p) : longint'(p);
        endfunction

        function longint wide_clip(longint v);
            if (v > WIDE_LIMIT)
                return WIDE_LIMIT;
            if (v < -WIDE_LIMIT)
                return -WIDE_LIMIT;
            return v;
        endfunction

        // The ceiling wins when the floor sits above it.
        function longint clip_to_limits(longint v);
            if (v > longint'(regs.ceil_lim))
                return longint'(regs.ceil_lim);
            if (v < longint'(regs.floor_lim))
                return longint'(regs.floor_lim);
            return v;
        endfunction

        function void note_sample(logic signed [DATA_W-1:0] tgt,
                                  logic signed [DATA_W-1:0] meas,
                                  logic [BAND_W-1:0] band, logic [TIME_W-1:0] stamp);
            longint            err;
            longint            mag;
            longint            dt;
            longint            prop;
            longint            integ;
            longint            deriv;
            longint            drv;
            logic [TIME_W-1:0] elapsed;
            requests++;
            err = longint'(tgt) - longint'(meas);
            mag = (err < 0) ? -err : err;
            if (mag <= longint'(band)) begin
                in_band++;
                drive_q.push_back('0);
                return;
            end
            elapsed = stamp - last_stamp;
            dt      = longint'(elapsed);
            prop    = wide_product(longint'(regs.gain_p), err);
            integ   = longint'(integ_acc) +
                      wide_product(wide_product(longint'(regs.gain_i), err), dt);
            integ   = clip_to_limits(wide_clip(integ));
            if (dt == 0) begin
                zero_dt++;
                deriv = 0;
            end else begin
                deriv = wide_product(longint'(regs.gain_d),
                                     longint'(meas) - longint'(last_meas)) / dt;
            end
            drv = wide_clip(prop + integ);
            drv = wide_clip(drv - deriv);
            drv = clip_to_limits(drv);
            last_stamp = stamp;
            last_meas  = meas;
            integ_acc  = integ[DATA_W-1:0];
            drive_q.push_back(drv[DATA_W-1:0]);
        endfunction

        function void check_drive(logic signed [DATA_W-1:0] got);
            logic signed [DATA_W-1:0] want;
            checked++;
            if (drive_q.size() == 0) begin
                errors++;
                $display("%0t: drive %0d arrived with no request outstanding", $time, got);
                return;
            end
            want = drive_q.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: drive mismatch, expected %0d, actual %0d", $time, want, got);
            end
        endfunction

        function int pending();
            return drive_q.size();
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic signed [DATA_W-1:0] i_target;
    logic signed [DATA_W-1:0] i_measured;
    logic [BAND_W-1:0]        i_deadband;
    logic [TIME_W-1:0]        i_timestamp_us;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [DATA_W-1:0] o_drive;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [DATA_W-1:0]        i_cfg_data;

    pid_scoreboard            sb;
    int                       sender_idle_pct = 0;
    int                       recv_stall_pct  = 0;
    int                       settings_used   = 0;
    logic [TIME_W-1:0]        sent_stamp      = '0;
    logic signed [DATA_W-1:0] sent_meas       = '0;

    pid_integer_deadband_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_target       (i_target),
        .i_measured     (i_measured),
        .i_deadband     (i_deadband),
        .i_timestamp_us (i_timestamp_us),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_drive        (o_drive),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Valid is left high after a write so that back-to-back writes never
    // lower and raise it in the same step; the caller lowers it at the end.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_setting(input logic signed [GAIN_W-1:0] gp, gi, gd,
                                 input logic signed [DATA_W-1:0] lo, hi);
        cfg_write(REG_GAIN_P, {(DATA_W-GAIN_W)'($urandom), gp});
        cfg_write(REG_GAIN_I, {(DATA_W-GAIN_W)'($urandom), gi});
        cfg_write(REG_GAIN_D, {(DATA_W-GAIN_W)'($urandom), gd});
        cfg_write(REG_FLOOR, lo);
        cfg_write(REG_CEILING, hi);
        // A write past the last register must leave everything alone.
        cfg_write(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, REG_CEILING + 1)),
                  DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Valid stays high after acceptance; the next request or a gap replaces it.
    task automatic send_sample(input logic signed [DATA_W-1:0] tgt, meas,
                               input logic [BAND_W-1:0] band, input logic [TIME_W-1:0] stamp);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_target       <= tgt;
        i_measured     <= meas;
        i_deadband     <= band;
        i_timestamp_us <= stamp;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_sample(tgt, meas, band, stamp);
        sent_stamp = stamp;
        sent_meas  = meas;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_directed();
        // Reset gains are zero, so even outside the band the drive stays zero.
        send_sample(5, 0, 0, 100);
        drain_results();
        apply_setting(3, 2, 7, DATA_MIN, DATA_MAX);
        send_sample(1000, 0, 999, 200);
        send_sample(1000, 0, 1000, 250);
        // Derivative division by three rounds toward zero in both directions.
        send_sample(1000, 10, 0, 203);
        send_sample(-1000, 0, 0, 206);
        send_sample(-1000, 0, 0, 206);
        send_sample(0, 5, 0, 32'hFFFF_FFF0);
        send_sample(0, 5, 0, 32'h0000_0010);
        send_sample(DATA_MAX, DATA_MIN, 0, 1000);
        send_sample(DATA_MIN, DATA_MAX, 0, 2000);
        send_sample(0, 0, BAND_MAX, 2100);
        send_sample(DATA_MAX, DATA_MIN, BAND_MAX, 2200);
        send_sample(0, DATA_MAX, BAND_MAX, 2300);
        drain_results();
        // Full-scale gains with huge elapsed time drive the wide integral product into saturation.
        apply_setting(GAIN_MIN, GAIN_MAX, GAIN_MIN, DATA_MIN, DATA_MAX);
        send_sample(DATA_MAX, DATA_MIN, 0, 32'hFFFF_0000);
        send_sample(DATA_MIN, DATA_MAX, 0, 32'hFFFF_0001);
        send_sample(DATA_MAX, DATA_MIN, 0, 32'h7FFF_0000);
        drain_results();
        apply_setting(GAIN_MAX, GAIN_MIN, GAIN_MAX, 1000, -1000);
        send_sample(5000, 0, 0, 32'h7FFF_0100);
        send_sample(-5000, 0, 0, 32'h7FFF_0200);
        send_sample(0, 0, 0, 32'h7FFF_0300);
        drain_results();
        apply_setting(2, 1, 3, -77, -77);
        send_sample(100, 0, 0, 32'h7FFF_0400);
        send_sample(-100, 0, 0, 32'h7FFF_0500);
        drain_results();
    endtask

    task automatic random_setting(input int blk);
        logic signed [GAIN_W-1:0] g[3];
        logic signed [GAIN_W-1:0] s[3];
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic signed [DATA_W-1:0] t;
        for (int k = 0; k < 3; k++) begin
            g[k] = GAIN_W'($urandom);
            s[k] = GAIN_W'($urandom_range(32) - 16);
        end
        a = DATA_W'($urandom);
        b = DATA_W'($urandom);
        if (a > b) begin
            t = a;
            a = b;
            b = t;
        end
        case (blk)
            0: apply_setting(g[0], g[1], g[2], DATA_MIN, DATA_MAX);
            1: apply_setting(s[0], s[1], s[2], DATA_MIN, DATA_MAX);
            2: apply_setting($urandom_range(1) ? GAIN_MAX : GAIN_MIN,
                             $urandom_range(1) ? GAIN_MAX : GAIN_MIN,
                             $urandom_range(1) ? GAIN_MAX : GAIN_MIN, DATA_MIN, DATA_MAX);
            3: apply_setting(s[0], s[1], s[2], b, a);
            4: apply_setting(g[0], g[1], g[2], a, b);
            default: apply_setting(s[0], s[1], s[2], a, b);
        endcase
    endtask

    // Mostly a plausible loop: slowly moving measurement and steady time steps.
    task automatic send_random_sample();
        logic signed [DATA_W-1:0] tgt;
        logic signed [DATA_W-1:0] meas;
        logic [BAND_W-1:0]        band;
        logic [TIME_W-1:0]        stamp;
        int                       pick;
        pick = $urandom_range(99);
        if (pick < 70)
            stamp = sent_stamp + $urandom_range(2000, 1);
        else if (pick < 80)
            stamp = sent_stamp;
        else if (pick < 90)
            stamp = sent_stamp + $urandom;
        else
            stamp = $urandom;
        if ($urandom_range(99) < 60)
            meas = DATA_W'(int'(sent_meas) + int'($urandom_range(4000)) - 2000);
        else
            meas = DATA_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 50)
            tgt = DATA_W'(int'(meas) + int'($urandom_range(6000)) - 3000);
        else if (pick < 80)
            tgt = DATA_W'($urandom);
        else
            tgt = meas;
        pick = $urandom_range(99);
        if (pick < 50)
            band = BAND_W'($urandom_range(2000));
        else if (pick < 80)
            band = '0;
        else
            band = BAND_W'($urandom);
        send_sample(tgt, meas, band, stamp);
    endtask

    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                sb.check_drive(o_drive);
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial begin
        sb = new();
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_target       <= '0;
        i_measured     <= '0;
        i_deadband     <= '0;
        i_timestamp_us <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            if (blk < 2) begin
                sender_idle_pct = 31;
                recv_stall_pct  = 73;
            end else if (blk < 4) begin
                sender_idle_pct = 73;
                recv_stall_pct  = 31;
            end else begin
                sender_idle_pct = 0;
                recv_stall_pct  = 0;
            end
            random_setting(blk);
            repeat (BLOCK_REQUESTS) begin
                send_random_sample();
                // Now and then hold off until the block has emptied completely.
                if ($urandom_range(63) == 0)
                    drain_results();
            end
            drain_results();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Covered %0d requests over %0d register settings: %0d inside the deadband,",
                 sb.requests, settings_used, sb.in_band);
        $display("%0d with zero elapsed time; %0d drive values checked, %0d errors.",
                 sb.zero_dt, sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("Timeout at %0t with %0d drive values outstanding", $time, sb.pending());
        $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
src/pidd_pkg.sv
src/pidd_cfg.sv
src/pidd_mul.sv
src/pidd_div.sv
src/pid_integer_deadband_unit.sv
src/pidd_checker.sv
dv/tb_top.sv
